// ===== hdl/tpc_pkg.sv =====
// ----------------------------------------------------------------------------
// tpc_pkg
// Shared types, register codes and constants of the triangle project-and-cull
// core.
// ----------------------------------------------------------------------------
package tpc_pkg;

  localparam int FRAC_BITS_DEF  = 16;
  localparam int ANGLE_BITS_DEF = 16;

  localparam int COORD_W    = 32;
  localparam int ANGLE_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // internal vertex width: rotated coordinates and depth
  localparam int VERT_W = 48;
  // width of the clamped perspective quotient
  localparam int QUOT_W = 40;
  // sine/cosine pipeline depth
  localparam int TRIG_STAGES = 7;
  // polynomial term width
  localparam int T_W = 34;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_SCALE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z      = 3'd4;

  localparam logic [12:0]        RST_SCREEN_WIDTH  = 13'd640;
  localparam logic [12:0]        RST_SCREEN_HEIGHT = 13'd480;
  localparam logic [15:0]        RST_FOCAL_SCALE   = 16'd300;
  localparam logic signed [15:0] RST_OFFSET_Y      = 16'sd70;
  localparam logic signed [15:0] RST_OFFSET_Z      = 16'sd150;

  // vertex slot codes
  localparam logic [1:0] VTX_A = 2'd0;
  localparam logic [1:0] VTX_B = 2'd1;
  localparam logic [1:0] VTX_C = 2'd2;

  // quarter-wave sine polynomial, Q30
  localparam logic signed [T_W-1:0] SIN_C1 = 34'sd1686629713;
  localparam logic signed [T_W-1:0] SIN_C3 = 34'sd693598668;
  localparam logic signed [T_W-1:0] SIN_C5 = 34'sd85569306;
  localparam logic signed [T_W-1:0] SIN_C7 = 34'sd5026995;
  localparam logic signed [T_W-1:0] SIN_C9 = 34'sd172272;
  localparam logic [30:0]           Q30_ONE = 31'h4000_0000;

  typedef struct packed {
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] az;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by_coord;
    logic signed [COORD_W-1:0] bz;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] cz;
    logic [ANGLE_W-1:0]        spin_angle;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] screen_ax;
    logic signed [COORD_W-1:0] screen_ay;
    logic signed [COORD_W-1:0] screen_bx;
    logic signed [COORD_W-1:0] screen_by;
    logic signed [COORD_W-1:0] screen_cx;
    logic signed [COORD_W-1:0] screen_cy;
    logic                      visible;
    logic                      depth_fault;
  } out_item_t;

  typedef struct packed {
    logic [12:0]        screen_width;
    logic [12:0]        screen_height;
    logic [15:0]        focal_scale;
    logic signed [15:0] offset_y;
    logic signed [15:0] offset_z;
  } cfg_t;

  typedef struct packed {
    logic                      valid;
    in_item_t                  item;
    logic signed [COORD_W-1:0] sn;
    logic signed [COORD_W-1:0] cs;
  } trig_out_t;

  typedef struct packed {
    logic                      valid;
    logic [1:0]                idx;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] sn;
    logic signed [COORD_W-1:0] cs;
  } vtx_in_t;

  typedef struct packed {
    logic                      valid;
    logic [1:0]                idx;
    logic                      fault;
    logic signed [COORD_W-1:0] sx;
    logic signed [COORD_W-1:0] sy;
  } vtx_out_t;

endpackage

// ===== hdl/triangle_project_and_cull_core.sv =====
// ----------------------------------------------------------------------------
// triangle_project_and_cull_core
// Rotates, projects and back-face tests one triangle per command.
// ----------------------------------------------------------------------------
// Path: the command runs through the sine/cosine pipeline, vertex issue,
//   rotate, divide and scale/saturate; the later vertices follow vertex A,
//   and the cull stage then drives the result strobe.
// Throughput: a triangle is taken whenever busy is low, overlapping earlier ones;
//   the vertices go one per cycle through a single pair of pipelined dividers.
// Reset: synchronous, active low; clears valids, busy and the registers to
//   their defaults. No result strobes until a command is accepted.
module triangle_project_and_cull_core
  import tpc_pkg::*;
#(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // command transfer
  input  logic                  start,
  input  in_item_t              in_item,
  output logic                  busy,
  // result transfer, one-cycle strobe
  output logic                  out_valid,
  output out_item_t             out_result,
  // register writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  typedef enum logic [1:0] {SER_IDLE, SER_V1, SER_V2} ser_state_t;

  cfg_t       cfg_r;
  logic [1:0] busy_cnt_r, busy_cnt_nxt;
  logic       accept;

  trig_out_t  trig;
  trig_out_t  tri_buf_r;
  ser_state_t ser_state_r;
  vtx_in_t    vtx_r;
  vtx_out_t   vtx_res;

  // Register file. The user must write only while the core is idle; the block itself does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.screen_width  <= RST_SCREEN_WIDTH;
      cfg_r.screen_height <= RST_SCREEN_HEIGHT;
      cfg_r.focal_scale   <= RST_FOCAL_SCALE;
      cfg_r.offset_y      <= RST_OFFSET_Y;
      cfg_r.offset_z      <= RST_OFFSET_Z;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCREEN_WIDTH:  cfg_r.screen_width  <= cfg_wdata[12:0];
        REG_SCREEN_HEIGHT: cfg_r.screen_height <= cfg_wdata[12:0];
        REG_FOCAL_SCALE:   cfg_r.focal_scale   <= cfg_wdata;
        REG_OFFSET_Y:      cfg_r.offset_y      <= $signed(cfg_wdata);
        REG_OFFSET_Z:      cfg_r.offset_z      <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  // Command accept. Each triangle needs the vertex issue slot for its three
  // vertices, so busy holds off the next command until the busy counter runs down.
  assign accept = start && !busy;
  assign busy   = busy_cnt_r != 2'd0;

  always_comb begin
    busy_cnt_nxt = busy_cnt_r;
    if (accept)
      busy_cnt_nxt = 2'd2;
    else if (busy_cnt_r != 2'd0)
      busy_cnt_nxt = busy_cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n)
      busy_cnt_r <= 2'd0;
    else
      busy_cnt_r <= busy_cnt_nxt;
  end

  // Sine and cosine of the spin angle; the triangle rides along.
  tpc_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sincos (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (accept),
    .in_item  (in_item),
    .trig     (trig)
  );

  // Vertex issue: vertex A is registered when the angle is ready, then B and C
  // from the buffered triangle. Busy keeps triangles far enough apart
  // that a new one never lands while B or C is still pending.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_state_r <= SER_IDLE;
      vtx_r.valid <= 1'b0;
    end else begin
      vtx_r.valid <= 1'b0;
      if (trig.valid) begin
        tri_buf_r   <= trig;
        vtx_r.valid <= 1'b1;
        vtx_r.idx   <= VTX_A;
        vtx_r.x     <= trig.item.ax;
        vtx_r.y     <= trig.item.ay;
        vtx_r.z     <= trig.item.az;
        vtx_r.sn    <= trig.sn;
        vtx_r.cs    <= trig.cs;
        ser_state_r <= SER_V1;
      end else begin
        unique case (ser_state_r)
          SER_V1: begin
            vtx_r.valid <= 1'b1;
            vtx_r.idx   <= VTX_B;
            vtx_r.x     <= tri_buf_r.item.bx;
            vtx_r.y     <= tri_buf_r.item.by_coord;
            vtx_r.z     <= tri_buf_r.item.bz;
            ser_state_r <= SER_V2;
          end
          SER_V2: begin
            vtx_r.valid <= 1'b1;
            vtx_r.idx   <= VTX_C;
            vtx_r.x     <= tri_buf_r.item.cx;
            vtx_r.y     <= tri_buf_r.item.cy;
            vtx_r.z     <= tri_buf_r.item.cz;
            ser_state_r <= SER_IDLE;
          end
          default: ser_state_r <= SER_IDLE;
        endcase
      end
    end
  end

  // Rotate, offset, divide by depth, scale, center and saturate.
  tpc_vertex #(.FRAC_BITS(FRAC_BITS)) u_vertex (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .vin   (vtx_r),
    .vout  (vtx_res)
  );

  // Collect the three vertices and decide visibility.
  tpc_cull u_cull (
    .clk        (clk),
    .rst_n      (rst_n),
    .vin        (vtx_res),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

endmodule

// ===== hdl/tpc_sincos.sv =====
// ----------------------------------------------------------------------------
// tpc_sincos
// Seven-stage sine/cosine pipeline; carries the triangle alongside.
// ----------------------------------------------------------------------------
module tpc_sincos
  import tpc_pkg::*;
#(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  in_item_t  in_item,
  output trig_out_t trig
);

  localparam int QS = ANGLE_BITS - 2;

  logic                      vld_r  [TRIG_STAGES];
  in_item_t                  item_r [TRIG_STAGES];
  logic signed [COORD_W-1:0] lane_val [2];
  logic [ANGLE_BITS-1:0]     ang;
  logic [ANGLE_BITS+ANGLE_W-1:0] ang_ext;

  assign ang_ext = {{ANGLE_BITS{1'b0}}, in_item.spin_angle};
  assign ang     = ang_ext[ANGLE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TRIG_STAGES; i++) vld_r[i] <= 1'b0;
    end else begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < TRIG_STAGES; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    item_r[0] <= in_item;
    for (int i = 1; i < TRIG_STAGES; i++) item_r[i] <= item_r[i-1];
  end

  // lane 0 sine, lane 1 cosine (angle plus a quarter turn)
  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [ANGLE_BITS-1:0] ang_l;
    logic [QS-1:0]         rr;
    logic [30:0]           u_raw, u0;
    logic [30:0]           u1, u2, u3, u4, u5;
    logic                  n1, n2, n3, n4, n5, n6;
    logic [61:0]           pp1;
    logic [30:0]           q2, q3, q4;
    logic signed [65:0]    pr2, pr3, pr4, pr5, pr6;
    logic signed [T_W-1:0] t3, t4, t5, t6, t7;
    logic [30:0]           mag7;
    logic signed [COORD_W-1:0] val_r;

    always_comb begin
      ang_l = (l == 1) ? ang + (ANGLE_BITS'(1) << QS) : ang;
      rr    = ang_l[QS-1:0];
      u_raw = 31'({rr, {(30 - QS){1'b0}}});
      u0    = ang_l[QS] ? Q30_ONE - u_raw : u_raw;
      t3    = $signed(pr2[63:30]) - SIN_C7;
      t4    = $signed(pr3[63:30]) + SIN_C5;
      t5    = $signed(pr4[63:30]) - SIN_C3;
      t6    = $signed(pr5[63:30]) + SIN_C1;
      t7    = $signed(pr6[63:30]);
      if (t7 < 0)
        mag7 = '0;
      else if (t7 > $signed({3'b000, Q30_ONE}))
        mag7 = Q30_ONE;
      else
        mag7 = t7[30:0];
    end

    always_ff @(posedge clk) begin
      u1  <= u0;
      n1  <= ang_l[ANGLE_BITS-1];
      pp1 <= u0 * u0;
      u2  <= u1;
      n2  <= n1;
      q2  <= pp1[60:30];
      pr2 <= SIN_C9 * $signed({1'b0, pp1[60:30]});
      u3  <= u2;
      n3  <= n2;
      q3  <= q2;
      pr3 <= t3 * $signed({1'b0, q2});
      u4  <= u3;
      n4  <= n3;
      q4  <= q3;
      pr4 <= t4 * $signed({1'b0, q3});
      u5  <= u4;
      n5  <= n4;
      pr5 <= t5 * $signed({1'b0, q4});
      n6  <= n5;
      pr6 <= t6 * $signed({1'b0, u5});
      val_r <= n6 ? -$signed({1'b0, mag7}) : $signed({1'b0, mag7});
    end

    assign lane_val[l] = val_r;
  end

  assign trig.valid = vld_r[TRIG_STAGES-1];
  assign trig.item  = item_r[TRIG_STAGES-1];
  assign trig.sn    = lane_val[0];
  assign trig.cs    = lane_val[1];

endmodule

// ===== hdl/tpc_div.sv =====
// ----------------------------------------------------------------------------
// tpc_div
// Pipelined restoring divider, one quotient bit per stage, quotient clamped.
// ----------------------------------------------------------------------------
module tpc_div
  import tpc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic signed [VERT_W-1:0] num,
  input  logic [VERT_W-1:0]        den,
  output logic                     neg,
  output logic [QUOT_W:0]          quot
);

  localparam int DW    = VERT_W + FRAC_BITS;
  localparam int REM_W = VERT_W + 1;

  logic [VERT_W-1:0] mag;
  logic [DW-1:0]     dvd;
  logic [REM_W-1:0]  rem0;

  logic [REM_W-1:0]  rem_r   [QUOT_W+1];
  logic [QUOT_W-1:0] low_r   [QUOT_W+1];
  logic [QUOT_W-1:0] q_r     [QUOT_W+1];
  logic [VERT_W-1:0] den_r   [QUOT_W+1];
  logic              neg_r   [QUOT_W+1];
  logic              clamp_r [QUOT_W+1];

  always_comb begin
    mag  = num[VERT_W-1] ? VERT_W'(-num) : VERT_W'(num);
    dvd  = {mag, {FRAC_BITS{1'b0}}};
    rem0 = REM_W'(dvd[DW-1:QUOT_W]);
  end

  // head of the dividend at or above the divisor: quotient reaches the limit
  always_ff @(posedge clk) begin
    rem_r[0]   <= rem0;
    low_r[0]   <= dvd[QUOT_W-1:0];
    q_r[0]     <= '0;
    den_r[0]   <= den;
    neg_r[0]   <= num[VERT_W-1];
    clamp_r[0] <= rem0 >= {1'b0, den};
  end

  for (genvar k = 0; k < QUOT_W; k++) begin : g_step
    logic [REM_W-1:0] trial;
    logic             ge;

    assign trial = {rem_r[k][REM_W-2:0], low_r[k][QUOT_W-1]};
    assign ge    = trial >= {1'b0, den_r[k]};

    always_ff @(posedge clk) begin
      rem_r[k+1]   <= ge ? trial - {1'b0, den_r[k]} : trial;
      low_r[k+1]   <= low_r[k] << 1;
      q_r[k+1]     <= {q_r[k][QUOT_W-2:0], ge};
      den_r[k+1]   <= den_r[k];
      neg_r[k+1]   <= neg_r[k];
      clamp_r[k+1] <= clamp_r[k];
    end
  end

  assign neg  = neg_r[QUOT_W];
  assign quot = clamp_r[QUOT_W] ? {1'b1, {QUOT_W{1'b0}}} : {1'b0, q_r[QUOT_W]};

endmodule

// ===== hdl/tpc_vertex.sv =====
// ----------------------------------------------------------------------------
// tpc_vertex
// Vertex pipeline: rotate, offset, perspective divide, scale, center, saturate.
// ----------------------------------------------------------------------------
module tpc_vertex
  import tpc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  vtx_in_t  vin,
  output vtx_out_t vout
);

  localparam int DIV_LAT = QUOT_W + 1;
  localparam int PRJ_W   = QUOT_W + 17;

  // stage 1: products
  logic signed [32:0] z1, y1;
  logic signed [64:0] pa_r, pb_r, pc_r, pd_r;
  logic signed [32:0] y1_r;
  logic               v1_r;
  logic [1:0]         i1_r;

  // stage 2: rotated and offset coordinates
  logic signed [65:0]       xs, zs;
  logic signed [VERT_W-1:0] offy, offz, zr;
  logic signed [VERT_W-1:0] xr_r, yr_r, zr_r;
  logic                     v2_r, f2_r;
  logic [1:0]               i2_r;

  // divider side band
  logic       vd_r [DIV_LAT];
  logic [1:0] id_r [DIV_LAT];
  logic       fd_r [DIV_LAT];

  logic              nx, ny;
  logic [QUOT_W:0]   qx, qy;

  // scale and output stages
  logic [PRJ_W-1:0]  px_r, py_r;
  logic              nx_r, ny_r, vm_r, fm_r;
  logic [1:0]        im_r;
  logic signed [63:0] ctrx, ctry, dx, dy;

  assign z1 = 33'd0 - {vin.y[COORD_W-1], vin.y};
  assign y1 = 33'd0 - {vin.z[COORD_W-1], vin.z};

  always_ff @(posedge clk) begin
    pa_r <= $signed(vin.x) * $signed(vin.cs);
    pb_r <= z1 * $signed(vin.sn);
    pc_r <= z1 * $signed(vin.cs);
    pd_r <= $signed(vin.x) * $signed(vin.sn);
    y1_r <= y1;
    i1_r <= vin.idx;
  end

  always_comb begin
    offy = $signed({{(VERT_W-16){cfg.offset_y[15]}}, cfg.offset_y}) <<< FRAC_BITS;
    offz = $signed({{(VERT_W-16){cfg.offset_z[15]}}, cfg.offset_z}) <<< FRAC_BITS;
    xs   = 66'(pa_r) - 66'(pb_r) + 66'sd536870912;
    zs   = 66'(pc_r) + 66'(pd_r) + 66'sd536870912;
    zr   = VERT_W'($signed(zs[65:30])) + offz;
  end

  always_ff @(posedge clk) begin
    xr_r <= VERT_W'($signed(xs[65:30]));
    yr_r <= VERT_W'(y1_r) + offy;
    zr_r <= zr;
    f2_r <= (zr <= 0);
    i2_r <= i1_r;
  end

  tpc_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
    .clk  (clk),
    .num  (xr_r),
    .den  (zr_r),
    .neg  (nx),
    .quot (qx)
  );

  tpc_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
    .clk  (clk),
    .num  (yr_r),
    .den  (zr_r),
    .neg  (ny),
    .quot (qy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      for (int i = 0; i < DIV_LAT; i++) vd_r[i] <= 1'b0;
      vm_r <= 1'b0;
    end else begin
      v1_r <= vin.valid;
      v2_r <= v1_r;
      vd_r[0] <= v2_r;
      for (int i = 1; i < DIV_LAT; i++) vd_r[i] <= vd_r[i-1];
      vm_r <= vd_r[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    id_r[0] <= i2_r;
    fd_r[0] <= f2_r;
    for (int i = 1; i < DIV_LAT; i++) begin
      id_r[i] <= id_r[i-1];
      fd_r[i] <= fd_r[i-1];
    end
    px_r <= qx * cfg.focal_scale;
    py_r <= qy * cfg.focal_scale;
    nx_r <= nx;
    ny_r <= ny;
    im_r <= id_r[DIV_LAT-1];
    fm_r <= fd_r[DIV_LAT-1];
  end

  always_comb begin
    ctrx = 64'(cfg.screen_width[12:1]) << FRAC_BITS;
    ctry = 64'(cfg.screen_height[12:1]) << FRAC_BITS;
    dx   = nx_r ? ctrx + 64'(px_r) : ctrx - 64'(px_r);
    dy   = ny_r ? ctry + 64'(py_r) : ctry - 64'(py_r);
  end

  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647)
      return 32'sh7fff_ffff;
    else if (v < -64'sd2147483648)
      return 32'sh8000_0000;
    else
      return v[COORD_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n)
      vout.valid <= 1'b0;
    else
      vout.valid <= vm_r;
    vout.idx   <= im_r;
    vout.fault <= fm_r;
    vout.sx    <= sat32(dx);
    vout.sy    <= sat32(dy);
  end

endmodule

// ===== hdl/tpc_cull.sv =====
// ----------------------------------------------------------------------------
// tpc_cull
// Gathers three screen vertices, runs the winding test, drives the result.
// ----------------------------------------------------------------------------
module tpc_cull
  import tpc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  vtx_out_t  vin,
  output logic      out_valid,
  output out_item_t out_result
);

  logic signed [COORD_W-1:0] sx0_r, sy0_r, sx1_r, sy1_r;
  logic                      f0_r, f1_r;

  logic                      tri_fault;
  logic signed [32:0]        d20x, d21y, d31y, d40x;
  logic signed [65:0]        p_r, q_r;
  logic signed [COORD_W-1:0] s_r [6];
  logic                      c1_v_r, c1_f_r;

  always_ff @(posedge clk) begin
    if (vin.valid && vin.idx == VTX_A) begin
      sx0_r <= vin.sx;
      sy0_r <= vin.sy;
      f0_r  <= vin.fault;
    end
    if (vin.valid && vin.idx == VTX_B) begin
      sx1_r <= vin.sx;
      sy1_r <= vin.sy;
      f1_r  <= vin.fault;
    end
  end

  always_comb begin
    tri_fault = f0_r | f1_r | vin.fault;
    d20x = $signed({sx1_r[31], sx1_r}) - $signed({sx0_r[31], sx0_r});
    d21y = $signed({vin.sy[31], vin.sy}) - $signed({sy0_r[31], sy0_r});
    d31y = $signed({sy1_r[31], sy1_r}) - $signed({sy0_r[31], sy0_r});
    d40x = $signed({vin.sx[31], vin.sx}) - $signed({sx0_r[31], sx0_r});
  end

  // winding products; faulted triangles report zero coordinates
  always_ff @(posedge clk) begin
    p_r    <= d20x * d21y;
    q_r    <= d31y * d40x;
    c1_f_r <= tri_fault;
    s_r[0] <= tri_fault ? '0 : sx0_r;
    s_r[1] <= tri_fault ? '0 : sy0_r;
    s_r[2] <= tri_fault ? '0 : sx1_r;
    s_r[3] <= tri_fault ? '0 : sy1_r;
    s_r[4] <= tri_fault ? '0 : vin.sx;
    s_r[5] <= tri_fault ? '0 : vin.sy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_v_r    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      c1_v_r    <= vin.valid && vin.idx == VTX_C;
      out_valid <= c1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    out_result.screen_ax   <= s_r[0];
    out_result.screen_ay   <= s_r[1];
    out_result.screen_bx   <= s_r[2];
    out_result.screen_by   <= s_r[3];
    out_result.screen_cx   <= s_r[4];
    out_result.screen_cy   <= s_r[5];
    out_result.visible     <= !c1_f_r && !(p_r > q_r);
    out_result.depth_fault <= c1_f_r;
  end

endmodule

// ===== hdl/tpc_checker.sv =====
// ----------------------------------------------------------------------------
// tpc_checker
// Port-level checks of the triangle project-and-cull core.
// ----------------------------------------------------------------------------
module tpc_checker
  import tpc_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input out_item_t out_result
);

  localparam int LAT = 57;

  // a command raises busy, holding off the next, and busy then falls again
  a_busy_window: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy ##1 busy ##1 !busy)
    else $error("busy window after command transfer is wrong");

  a_result_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid ##1 !out_valid)
    else $error("results closer than three cycles");

  a_result_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without matching command transfer");

  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result.depth_fault) |->
      (!out_result.visible && out_result.screen_ax == 0 &&
       out_result.screen_ay == 0 && out_result.screen_bx == 0 &&
       out_result.screen_by == 0 && out_result.screen_cx == 0 &&
       out_result.screen_cy == 0))
    else $error("faulted triangle reports coordinates or visible");

endmodule

bind triangle_project_and_cull_core tpc_checker u_checker (.*);
